// File: rtl/core/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared definitions of the perspective floor scanline renderer
// Types, register indexes, trig table and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package pfs_pkg;

   localparam int LINE_PIXELS_DEF     = 640;
   localparam int PIXELS_PER_WORD_DEF = 16;
   localparam int SCREEN_LINES_DEF    = 480;

   localparam int WORD_BITS  = 64;
   localparam int ROW_BITS   = 9;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_VIEW_ANGLE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_X       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_Y       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HORIZON_OFFSET = 3'd4;

   localparam logic [10:0] HEIGHT_RESET  = 11'd640;
   localparam logic [9:0]  HORIZON_RESET = 10'h3bc;  // -68

   localparam logic [18:0] DEPTH_SCALE = 19'd240;
   // floor(v / 5) == (v * RECIP_5) >> 18 for every v below 2^13
   localparam logic [28:0] RECIP_5     = 29'd52429;
   localparam logic [31:0] BETA_FIX    = 32'hffffff67;

   typedef struct packed {
      logic [5:0]  view_angle;
      logic [31:0] camera_x;
      logic [31:0] camera_y;
      logic [10:0] camera_height;
      logic [9:0]  horizon_offset;
   } cfg_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] dx;
      logic [31:0] dy;
      logic        blank;
      logic        div_err;
   } line_type;

   function automatic logic signed [9:0] sine_of(input logic [5:0] k);
      logic [8:0] mag;
      case (k[4:0])
         5'd0:  mag = 9'h000;  5'd1:  mag = 9'h019;  5'd2:  mag = 9'h031;
         5'd3:  mag = 9'h04a;  5'd4:  mag = 9'h061;  5'd5:  mag = 9'h078;
         5'd6:  mag = 9'h08e;  5'd7:  mag = 9'h0a2;  5'd8:  mag = 9'h0b5;
         5'd9:  mag = 9'h0c5;  5'd10: mag = 9'h0d4;  5'd11: mag = 9'h0e1;
         5'd12: mag = 9'h0ec;  5'd13: mag = 9'h0f4;  5'd14: mag = 9'h0fb;
         5'd15: mag = 9'h0fe;  5'd16: mag = 9'h100;  5'd17: mag = 9'h0fe;
         5'd18: mag = 9'h0fb;  5'd19: mag = 9'h0f4;  5'd20: mag = 9'h0ec;
         5'd21: mag = 9'h0e1;  5'd22: mag = 9'h0d4;  5'd23: mag = 9'h0c5;
         5'd24: mag = 9'h0b5;  5'd25: mag = 9'h0a2;  5'd26: mag = 9'h08e;
         5'd27: mag = 9'h078;  5'd28: mag = 9'h061;  5'd29: mag = 9'h04a;
         5'd30: mag = 9'h031;  5'd31: mag = 9'h019;
         default: mag = 9'h000;
      endcase
      return k[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic [31:0] asr8(input logic [31:0] v);
      return {{8{v[31]}}, v[31:8]};
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/pfs_if.sv
// ----------------------------------------------------------------------------
// pfs_if: channel interfaces of the scanline renderer
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfs_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] line_index;
   modport source (output valid, output line_index, input ready);
   modport sink   (input valid, input line_index, output ready);
endinterface

interface pfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] pixel_word;
   logic        last_word;
   logic        divide_error;
   modport source (output valid, output pixel_word, output last_word,
                   output divide_error, input ready);
   modport sink   (input valid, input pixel_word, input last_word,
                   input divide_error, output ready);
endinterface

interface pfs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/perspective_floor_scanline.sv
// ----------------------------------------------------------------------------
// perspective_floor_scanline: mode-7 style floor renderer, one row per request
// Setup front, two-entry line queue, and a pixel walker that emits words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   transfer
//  req_bus   in   line_index                                 one per row
//  rsp_bus   out  pixel_word, last_word, divide_error        WORD_COUNT per row
//  csr_bus   in   index, data                                one register write
//
// A row is WORD_COUNT words (40 by default). The walker emits one word per
// cycle while the response is not stalled, and rows stream back to back.
// Setup of a row runs through the 19-step distance divider and overlaps the
// previous row's output through the queue. Reset clears control only; the
// registers return to their defaults. A stalled response holds the walker in place.
`default_nettype none
module perspective_floor_scanline #(
   parameter int LINE_PIXELS     = pfs_pkg::LINE_PIXELS_DEF,
   parameter int PIXELS_PER_WORD = pfs_pkg::PIXELS_PER_WORD_DEF,
   parameter int SCREEN_LINES    = pfs_pkg::SCREEN_LINES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   pfs_req_if.sink   req_bus,
   pfs_rsp_if.source rsp_bus,
   pfs_csr_if.sink   csr_bus
);
   pfs_pkg::cfg_type  cfg_ff;
   pfs_pkg::line_type f_entry, q_data;
   logic              f_valid, f_ready, q_valid, q_pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_angle     <= '0;
         cfg_ff.camera_x       <= '0;
         cfg_ff.camera_y       <= '0;
         cfg_ff.camera_height  <= pfs_pkg::HEIGHT_RESET;
         cfg_ff.horizon_offset <= pfs_pkg::HORIZON_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            pfs_pkg::CSR_VIEW_ANGLE:     cfg_ff.view_angle     <= csr_bus.data[5:0];
            pfs_pkg::CSR_CAMERA_X:       cfg_ff.camera_x       <= csr_bus.data;
            pfs_pkg::CSR_CAMERA_Y:       cfg_ff.camera_y       <= csr_bus.data;
            pfs_pkg::CSR_CAMERA_HEIGHT:  cfg_ff.camera_height  <= csr_bus.data[10:0];
            pfs_pkg::CSR_HORIZON_OFFSET: cfg_ff.horizon_offset <= csr_bus.data[9:0];
            default: begin
            end
         endcase
      end
   end

   pfs_front #(
      .LINE_PIXELS (LINE_PIXELS),
      .SCREEN_LINES(SCREEN_LINES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg_ff),
      .entry      (f_entry),
      .entry_valid(f_valid),
      .entry_ready(f_ready)
   );

   pfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_data (f_entry),
      .wr_valid(f_valid),
      .wr_ready(f_ready),
      .rd_data (q_data),
      .rd_valid(q_valid),
      .rd_pop  (q_pop)
   );

   pfs_back #(
      .LINE_PIXELS    (LINE_PIXELS),
      .PIXELS_PER_WORD(PIXELS_PER_WORD)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_data (q_data),
      .q_valid(q_valid),
      .q_pop  (q_pop),
      .rsp    (rsp_bus)
   );

endmodule
`default_nettype wire

// File: rtl/core/pfs_front.sv
// ----------------------------------------------------------------------------
// pfs_front: per-line setup
// Classifies a row, divides for distance and computes start point and step.
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_front #(
   parameter int LINE_PIXELS  = pfs_pkg::LINE_PIXELS_DEF,
   parameter int SCREEN_LINES = pfs_pkg::SCREEN_LINES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   pfs_req_if.sink                 req,
   input  wire pfs_pkg::cfg_type   cfg,
   output pfs_pkg::line_type       entry,
   output logic                    entry_valid,
   input  wire logic               entry_ready
);
   localparam logic [31:0] HALF_FIX = 32'((LINE_PIXELS / 2) * 256);
   localparam int DIV_STEPS = 19;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_DIV   = 8'b00000010,
      S_RECIP = 8'b00000100,
      S_MUL1  = 8'b00001000,
      S_MUL2  = 8'b00010000,
      S_MUL3  = 8'b00100000,
      S_SUM   = 8'b01000000,
      S_PUSH  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  cnt_ff;
   logic [9:0]  rem_ff, div_ff;
   logic [18:0] quo_ff;
   logic        neg_ff;
   logic [31:0] dist_ff;
   logic [28:0] prod_ff;
   logic [31:0] dxp_ff, dyp_ff, pdc_ff, pds_ff, hc_ff, hs_ff;
   logic [31:0] mhc_ff, mhs_ff, hdx_ff, hdy_ff;
   pfs_pkg::line_type out_ff;

   logic signed [10:0] rowsum;
   logic signed [10:0] rowabs;
   logic               row_out;
   logic [10:0]        rem_sh;
   logic               q_bit;
   logic [31:0]        sin32, cos32, scale;
   logic [10:0]        uscale;

   assign rowsum  = $signed({2'b00, req.line_index}) +
                    $signed({cfg.horizon_offset[9], cfg.horizon_offset});
   assign rowabs  = rowsum[10] ? -rowsum : rowsum;
   assign row_out = 13'(req.line_index) >= 13'(SCREEN_LINES);
   assign rem_sh  = {rem_ff, quo_ff[18]};
   assign q_bit   = rem_sh >= {1'b0, div_ff};
   assign sin32   = 32'(pfs_pkg::sine_of(cfg.view_angle));
   assign cos32   = 32'(pfs_pkg::sine_of(cfg.view_angle + 6'd16));
   assign uscale  = prod_ff[28:18];
   assign scale   = neg_ff ? -32'(uscale) : 32'(uscale);

   assign req.ready   = state_ff == S_IDLE;
   assign entry_valid = state_ff == S_PUSH;
   assign entry       = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = (row_out || rowsum == 11'sd0) ? S_PUSH : S_DIV;
            end
         end
         S_DIV:   if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = S_RECIP;
         S_RECIP: state_in = S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_MUL3;
         S_MUL3:  state_in = S_SUM;
         S_SUM:   state_in = S_PUSH;
         S_PUSH:  if (entry_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cnt_ff         <= '0;
            rem_ff         <= '0;
            div_ff         <= rowabs[9:0];
            quo_ff         <= 19'(cfg.camera_height) * pfs_pkg::DEPTH_SCALE;
            neg_ff         <= rowsum[10];
            out_ff.blank   <= row_out || rowsum == 11'sd0;
            out_ff.div_err <= !row_out && rowsum == 11'sd0;
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_ff <= q_bit ? 10'(rem_sh - {1'b0, div_ff}) : rem_sh[9:0];
            quo_ff <= {quo_ff[17:0], q_bit};
            cnt_ff <= cnt_ff + 5'd1;
         end
         S_RECIP: begin
            dist_ff <= neg_ff ? -32'(quo_ff) : 32'(quo_ff);
            // |dist| / 320 = (|dist| >> 6) / 5
            prod_ff <= 29'(quo_ff[18:6]) * pfs_pkg::RECIP_5;
         end
         S_MUL1: begin
            dxp_ff <= (-sin32) * scale;
            dyp_ff <= cos32 * scale;
            pdc_ff <= dist_ff * cos32;
            pds_ff <= dist_ff * sin32;
            hc_ff  <= 32'(cfg.camera_height) * cos32;
            hs_ff  <= 32'(cfg.camera_height) * sin32;
         end
         S_MUL2: begin
            out_ff.dx <= pfs_pkg::asr8(dxp_ff);
            out_ff.dy <= pfs_pkg::asr8(dyp_ff);
            mhc_ff    <= pfs_pkg::BETA_FIX * pfs_pkg::asr8(hc_ff);
            mhs_ff    <= pfs_pkg::BETA_FIX * pfs_pkg::asr8(hs_ff);
         end
         S_MUL3: begin
            hdx_ff <= HALF_FIX * out_ff.dx;
            hdy_ff <= HALF_FIX * out_ff.dy;
         end
         S_SUM: begin
            out_ff.x <= cfg.camera_x + pfs_pkg::asr8(pdc_ff) - pfs_pkg::asr8(hdx_ff)
                        + pfs_pkg::asr8(mhc_ff);
            out_ff.y <= cfg.camera_y + pfs_pkg::asr8(pds_ff) - pfs_pkg::asr8(hdy_ff)
                        + pfs_pkg::asr8(mhs_ff);
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/pfs_queue.sv
// ----------------------------------------------------------------------------
// pfs_queue: two-entry line queue
// Decouples the setup stage from the pixel walker.
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfs_pkg::line_type wr_data,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   output pfs_pkg::line_type      rd_data,
   output logic                   rd_valid,
   input  wire logic              rd_pop
);
   pfs_pkg::line_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign wr_ready = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (rd_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(rd_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

// File: rtl/core/pfs_back.sv
// ----------------------------------------------------------------------------
// pfs_back: pixel walker
// Steps across the line and packs one word of tile colors per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_back #(
   parameter int LINE_PIXELS     = pfs_pkg::LINE_PIXELS_DEF,
   parameter int PIXELS_PER_WORD = pfs_pkg::PIXELS_PER_WORD_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfs_pkg::line_type q_data,
   input  wire logic              q_valid,
   output logic                   q_pop,
   pfs_rsp_if.source              rsp
);
   localparam int WORD_COUNT = (LINE_PIXELS + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
   localparam int WCW        = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
   localparam int LAST_LANES = LINE_PIXELS - (WORD_COUNT - 1) * PIXELS_PER_WORD;

   logic            active_ff;
   logic [WCW-1:0]  cnt_ff;
   logic [31:0]     x_ff, y_ff, dx_ff, dy_ff;
   logic            blank_ff, err_ff;
   logic            valid_ff, last_ff, err_out_ff;
   logic [63:0]     word_ff, word;
   logic            fire, is_last;

   assign is_last = cnt_ff == WCW'(WORD_COUNT - 1);
   assign fire    = active_ff && (!valid_ff || rsp.ready);
   assign q_pop   = q_valid && (!active_ff || (fire && is_last));

   always_comb begin
      word = '0;
      for (int k = 0; k < PIXELS_PER_WORD; k++) begin
         logic [31:0] lx, ly;
         lx = x_ff + 32'(k) * dx_ff;
         ly = y_ff + 32'(k) * dy_ff;
         if (!blank_ff && (!is_last || k < LAST_LANES)) begin
            word[4*k +: 4] = {lx[11:10], ly[11:10]};
         end
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.pixel_word   = word_ff;
   assign rsp.last_word    = last_ff;
   assign rsp.divide_error = err_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (q_pop) active_ff <= 1'b1;
         else if (fire && is_last) active_ff <= 1'b0;
         if (fire) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff    <= word;
         last_ff    <= is_last;
         err_out_ff <= err_ff;
      end
      if (q_pop) begin
         x_ff     <= q_data.x;
         y_ff     <= q_data.y;
         dx_ff    <= q_data.dx;
         dy_ff    <= q_data.dy;
         blank_ff <= q_data.blank;
         err_ff   <= q_data.div_err;
         cnt_ff   <= '0;
      end else if (fire) begin
         x_ff   <= x_ff + 32'(PIXELS_PER_WORD) * dx_ff;
         y_ff   <= y_ff + 32'(PIXELS_PER_WORD) * dy_ff;
         cnt_ff <= cnt_ff + WCW'(1);
      end
   end

endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the perspective floor scanline renderer
// Streams screen rows through several camera settings. Each accepted row is
// projected onto the tiled floor by a local model, and the forty pixel words
// that come back are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

   localparam int WORDS_PER_LINE = 40;
   localparam int PIX_PER_WORD   = 16;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [8:0] line;
      bit         drain;
   } row_job_type;

   typedef struct {
      logic [63:0] word;
      logic        last;
      logic        derr;
   } pixel_word_type;

   logic clock;
   logic reset;

   pfs_req_if req_bus();
   pfs_rsp_if rsp_bus();
   pfs_csr_if csr_bus();

   perspective_floor_scanline dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   row_job_type    row_jobs[$];
   pixel_word_type pixel_words_due[$];

   logic [5:0]  view_angle;
   logic [31:0] cam_x;
   logic [31:0] cam_y;
   logic [10:0] cam_height;
   logic [9:0]  horizon;

   int errors;
   int idle_cycles;
   bit row_taken;
   int burst_left;
   int gap_left;
   int stall_pct;
   int stall_run;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] p;
      p = a * b;
      return {{8{p[31]}}, p[31:8]};
   endfunction

   function automatic logic [31:0] fx_div(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] t;
      longint      n;
      longint      d;
      longint      q;
      t = a << 8;
      n = longint'($signed(t));
      d = longint'($signed(b));
      q = n / d;
      return q[31:0];
   endfunction

   function automatic logic [31:0] sine32(input logic [5:0] k);
      logic [31:0] mag [32];
      mag = '{32'h00, 32'h19, 32'h31, 32'h4a, 32'h61, 32'h78, 32'h8e, 32'ha2,
              32'hb5, 32'hc5, 32'hd4, 32'he1, 32'hec, 32'hf4, 32'hfb, 32'hfe,
              32'h100, 32'hfe, 32'hfb, 32'hf4, 32'hec, 32'he1, 32'hd4, 32'hc5,
              32'hb5, 32'ha2, 32'h8e, 32'h78, 32'h61, 32'h4a, 32'h31, 32'h19};
      return k[5] ? 32'd0 - mag[k[4:0]] : mag[k[4:0]];
   endfunction

   // project one row onto the floor and queue its pixel words
   task automatic project_row(input logic [8:0] line);
      logic [31:0] rowsum, s, c, distance, scale, dx, dy, x, y, h;
      logic        blank, derr;
      pixel_word_type pw;
      rowsum = {23'd0, line} + {{22{horizon[9]}}, horizon};
      h      = {21'd0, cam_height};
      blank  = (line >= 9'd480) || (rowsum == 0);
      derr   = (line < 9'd480) && (rowsum == 0);
      x = 0; y = 0; dx = 0; dy = 0;
      if (!blank) begin
         s        = sine32(view_angle);
         c        = sine32(view_angle + 6'd16);
         distance = fx_div(fx_mul(h, 32'd240 << 8), rowsum << 8);
         scale    = fx_div(distance, 32'd320 << 8);
         dx       = fx_mul(32'd0 - s, scale);
         dy       = fx_mul(c, scale);
         x = cam_x + fx_mul(distance, c) - fx_mul(32'd320 << 8, dx)
             + fx_mul(32'hffffff67, fx_mul(h, c));
         y = cam_y + fx_mul(distance, s) - fx_mul(32'd320 << 8, dy)
             + fx_mul(32'hffffff67, fx_mul(h, s));
      end
      for (int w = 0; w < WORDS_PER_LINE; w++) begin
         pw.word = '0;
         for (int p = 0; p < PIX_PER_WORD; p++) begin
            if (!blank) begin
               pw.word[4*p +: 4] = {x[11:10], y[11:10]};
               x = x + dx;
               y = y + dy;
            end
         end
         pw.last = (w == WORDS_PER_LINE - 1);
         pw.derr = derr;
         pixel_words_due.push_back(pw);
      end
   endtask

   // request side and watchdog, sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         row_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         row_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            project_row(req_bus.line_index);
            void'(row_jobs.pop_front());
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_words_due.size() == 0) begin
            report("unexpected word", rsp_bus.pixel_word, 64'd0);
         end else begin
            want = pixel_words_due.pop_front();
            if (rsp_bus.pixel_word !== want.word)
               report("pixel_word", rsp_bus.pixel_word, want.word);
            if (rsp_bus.last_word !== want.last)
               report("last_word", 64'(rsp_bus.last_word), 64'(want.last));
            if (rsp_bus.divide_error !== want.derr)
               report("divide_error", 64'(rsp_bus.divide_error), 64'(want.derr));
         end
      end
   end

   // row sender: bursts with gaps; hold valid until the transfer
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else if (req_bus.valid && !row_taken) begin
         req_bus.valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left      <= gap_left - 1;
      end else if (row_jobs.size() > 0 &&
                   (!row_jobs[0].drain || pixel_words_due.size() == 0)) begin
         req_bus.valid      <= 1'b1;
         req_bus.line_index <= row_jobs[0].line;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 60);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // response receiver: random stalls plus occasional long holds
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_run     <= 0;
      end else if (stall_run > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_run     <= stall_run - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_run     <= $urandom_range(5, 30);
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         pfs_pkg::CSR_VIEW_ANGLE:     view_angle = data[5:0];
         pfs_pkg::CSR_CAMERA_X:       cam_x      = data;
         pfs_pkg::CSR_CAMERA_Y:       cam_y      = data;
         pfs_pkg::CSR_CAMERA_HEIGHT:  cam_height = data[10:0];
         pfs_pkg::CSR_HORIZON_OFFSET: horizon    = data[9:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_camera(input logic [5:0] ang, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] h,
                               input logic [31:0] hz);
      csr_write(pfs_pkg::CSR_VIEW_ANGLE, {$urandom} & 32'hffffffc0 | {26'd0, ang});
      csr_write(pfs_pkg::CSR_CAMERA_X, x);
      csr_write(pfs_pkg::CSR_CAMERA_Y, y);
      csr_write(pfs_pkg::CSR_CAMERA_HEIGHT, h);
      csr_write(pfs_pkg::CSR_HORIZON_OFFSET, hz);
   endtask

   task automatic queue_row(input logic [8:0] line, input bit drain);
      row_job_type j;
      j.line  = line;
      j.drain = drain;
      row_jobs.push_back(j);
   endtask

   // directed rows for the current setting, then random rows
   task automatic run_phase(input int n_rand, input int pct);
      logic [31:0] zero_row;
      int          pick;
      stall_pct = pct;
      zero_row  = 32'd0 - {{22{horizon[9]}}, horizon};
      queue_row(9'd0, 1'b0);
      queue_row(9'd479, 1'b0);
      queue_row(9'd511, 1'b0);
      if (zero_row < 32'd480) begin
         queue_row(zero_row[8:0], 1'b0);
         if (zero_row > 0) queue_row(zero_row[8:0] - 9'd1, 1'b0);
         if (zero_row < 479) queue_row(zero_row[8:0] + 9'd1, 1'b1);
      end
      for (int i = 0; i < n_rand; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            queue_row(9'($urandom_range(480, 511)), 1'b0);
         else if (pick == 1 && zero_row < 32'd480)
            queue_row(zero_row[8:0], 1'b0);
         else
            queue_row(9'($urandom_range(0, 479)), ($urandom_range(0, 39) == 0));
      end
      while (row_jobs.size() > 0 || pixel_words_due.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      errors             = 0;
      stall_pct          = 0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.line_index = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      view_angle         = 6'd0;
      cam_x              = 32'd0;
      cam_y              = 32'd0;
      cam_height         = 11'd640;
      horizon            = 10'h3bc;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults, including a line that lands on the horizon
      queue_row(9'd480, 1'b0);
      queue_row(9'd256, 1'b0);
      queue_row(9'd255, 1'b0);
      run_phase(50, 0);

      write_camera(6'd63, 32'h7fffffff, 32'h80000000, 32'd1920, 32'd480);
      run_phase(50, 30);

      write_camera(6'd16, 32'h80000000, 32'h7fffffff, 32'd128, 32'h3e20); // -480
      run_phase(50, 60);

      // zero height and zero horizon: row 0 divides by zero
      write_camera(6'd32, 32'd0, 32'hffffffff, 32'hfffff800, 32'd0);
      run_phase(50, 10);

      write_camera(6'($urandom_range(0, 63)), $urandom, $urandom, $urandom, $urandom);
      run_phase(55, 0);

      write_camera(6'd48, $urandom, $urandom, $urandom_range(128, 1920),
                   $urandom_range(0, 960) - 480);
      run_phase(55, 40);

      write_camera(6'($urandom_range(0, 63)), $urandom, $urandom, 32'd2047, 32'h1ff);
      run_phase(45, 20);

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
